FILE: sv/data_stack_operation_unit_defines.svh
// ----------------------------------------------------------------------------
// Data stack operation unit: assertion macros
// Shared property wrappers for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef DATA_STACK_OPERATION_UNIT_DEFINES_SVH
`define DATA_STACK_OPERATION_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSOU_ASSERT_SAME(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSOU_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/dsou_pkg.sv
// ----------------------------------------------------------------------------
// Data stack operation unit package
// Port payload types, operation, tag and status codes, and decode helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package dsou_pkg;

  localparam int PORT_DATA_W = 64;
  localparam int TAG_W       = 3;
  localparam int OP_W        = 5;
  localparam int DEPTH_OUT_W = 7;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH      = 5'd0;
  localparam logic [OP_W-1:0] OP_CLEAR     = 5'd1;
  localparam logic [OP_W-1:0] OP_DEPTH     = 5'd2;
  localparam logic [OP_W-1:0] OP_DROP      = 5'd3;
  localparam logic [OP_W-1:0] OP_DROP2     = 5'd4;
  localparam logic [OP_W-1:0] OP_DUP       = 5'd5;
  localparam logic [OP_W-1:0] OP_DUP2      = 5'd6;
  localparam logic [OP_W-1:0] OP_NIP       = 5'd7;
  localparam logic [OP_W-1:0] OP_OVER      = 5'd8;
  localparam logic [OP_W-1:0] OP_ROT       = 5'd9;
  localparam logic [OP_W-1:0] OP_SWAP      = 5'd10;
  localparam logic [OP_W-1:0] OP_IS_BOOL   = 5'd11;
  localparam logic [OP_W-1:0] OP_IS_NUM    = 5'd12;
  localparam logic [OP_W-1:0] OP_IS_INT    = 5'd13;
  localparam logic [OP_W-1:0] OP_IS_REAL   = 5'd14;
  localparam logic [OP_W-1:0] OP_IS_RATIO  = 5'd15;
  localparam logic [OP_W-1:0] OP_IS_STRING = 5'd16;
  localparam logic [OP_W-1:0] OP_IS_LIST   = 5'd17;
  localparam logic [OP_W-1:0] OP_IS_FUNC   = 5'd18;

  // Value tags.
  localparam logic [TAG_W-1:0] TAG_BOOL     = 3'd0;
  localparam logic [TAG_W-1:0] TAG_INT      = 3'd1;
  localparam logic [TAG_W-1:0] TAG_REAL     = 3'd2;
  localparam logic [TAG_W-1:0] TAG_RATIO    = 3'd3;
  localparam logic [TAG_W-1:0] TAG_STRING   = 3'd4;
  localparam logic [TAG_W-1:0] TAG_LIST     = 3'd5;
  localparam logic [TAG_W-1:0] TAG_FUNCTION = 3'd6;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]        req_type;
    logic [TAG_W-1:0]       push_tag;
    logic [PORT_DATA_W-1:0] push_data;
  } req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [DEPTH_OUT_W-1:0] stack_depth;
    logic                   top_valid;
    logic [TAG_W-1:0]       top_tag;
    logic [PORT_DATA_W-1:0] top_data;
  } res_t;

  // Entries an operation needs on the stack.
  function automatic logic [1:0] need_of(input logic [OP_W-1:0] code);
    logic [1:0] n;
    n = 2'd0;
    if (code == OP_DROP || code == OP_DUP ||
        (code >= OP_IS_BOOL && code <= OP_IS_FUNC)) begin
      n = 2'd1;
    end else if (code == OP_DROP2 || code == OP_DUP2 || code == OP_NIP ||
                 code == OP_OVER || code == OP_SWAP) begin
      n = 2'd2;
    end else if (code == OP_ROT) begin
      n = 2'd3;
    end
    return n;
  endfunction

  // Entries an operation adds to the stack.
  function automatic logic [1:0] grow_of(input logic [OP_W-1:0] code);
    logic [1:0] g;
    g = 2'd0;
    if (code == OP_PUSH || code == OP_DEPTH || code == OP_DUP || code == OP_OVER) begin
      g = 2'd1;
    end else if (code == OP_DUP2) begin
      g = 2'd2;
    end
    return g;
  endfunction

  // Type predicate; a tag outside the defined set answers false.
  function automatic logic pred_hit(input logic [OP_W-1:0] code,
                                    input logic [TAG_W-1:0] tag);
    logic r;
    r = 1'b0;
    if (code == OP_IS_BOOL)   r = (tag == TAG_BOOL);
    if (code == OP_IS_NUM)    r = (tag == TAG_INT) || (tag == TAG_REAL) ||
                                  (tag == TAG_RATIO);
    if (code == OP_IS_INT)    r = (tag == TAG_INT);
    if (code == OP_IS_REAL)   r = (tag == TAG_REAL);
    if (code == OP_IS_RATIO)  r = (tag == TAG_RATIO);
    if (code == OP_IS_STRING) r = (tag == TAG_STRING);
    if (code == OP_IS_LIST)   r = (tag == TAG_LIST);
    if (code == OP_IS_FUNC)   r = (tag == TAG_FUNCTION);
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/dsou_ram.sv
// ----------------------------------------------------------------------------
// Data stack operation unit: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dsou_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/data_stack_operation_unit.sv
// A result appears with done, which is high for one cycle.
// Busy is high from the transfer until the result; no new operation is taken while busy.
// The entry RAM sets the pace: three reads of the top entries, then three write slots.
// Reset empties the stack (pointer to zero); the entry RAM keeps its contents.
// The receiver cannot stall; each result is offered once.
// ----------------------------------------------------------------------------
// Data stack operation unit
// Tagged data stack with Forth-style stack words and type predicates.
// ----------------------------------------------------------------------------
`default_nettype none

`include "data_stack_operation_unit_defines.svh"

module data_stack_operation_unit #(
  parameter int STACK_DEPTH = 64,
  parameter int DATA_WIDTH  = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire dsou_pkg::req_t  req,
  output logic                 busy,
  output logic                 done,
  output dsou_pkg::res_t       result
);

  import dsou_pkg::*;

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int PW  = $clog2(STACK_DEPTH + 1);
  localparam int PW1 = PW + 1;
  localparam int EW  = DATA_WIDTH + TAG_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_READ  = 3'b010,
    S_WRITE = 3'b100
  } state_t;

  state_t            state;
  logic [1:0]        cnt;
  logic [PW-1:0]     sp;
  logic [PW-1:0]     sp_new;
  logic [OP_W-1:0]   op;
  logic [1:0]        st;
  logic [EW-1:0]     push_ent;
  logic [EW-1:0]     e1;
  logic [EW-1:0]     e2;
  logic [EW-1:0]     e3;

  logic              accept;
  logic [PW1-1:0]    sp_ext;
  logic [1:0]        st_in;
  logic [PW-1:0]     sp_upd;
  logic [AW-1:0]     sp_a;
  logic [AW-1:0]     rd_addr;
  logic [EW-1:0]     rd_data;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [EW-1:0]     wr_data;
  logic [2:0]        slot_en;
  logic [AW-1:0]     slot_addr [3];
  logic [EW-1:0]     slot_data [3];
  logic [EW-1:0]     depth_ent;
  logic [EW-1:0]     bool_ent;
  logic [EW-1:0]     top_ent;
  logic [PW-1:0]     res_sp;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign sp_ext = {1'b0, sp};
  assign sp_a   = sp[AW-1:0];

  // Checks and pointer update, decided as the request is taken.
  always_comb begin
    st_in = ST_OK;
    if (sp_ext < PW1'(need_of(req.req_type))) begin
      st_in = ST_UNDER;
    end else if (sp_ext + PW1'(grow_of(req.req_type)) > PW1'(STACK_DEPTH)) begin
      st_in = ST_OVER;
    end
    sp_upd = sp;
    if (req.req_type == OP_PUSH || req.req_type == OP_DEPTH ||
        req.req_type == OP_DUP || req.req_type == OP_OVER) begin
      sp_upd = sp + PW'(1);
    end else if (req.req_type == OP_DUP2) begin
      sp_upd = sp + PW'(2);
    end else if (req.req_type == OP_DROP || req.req_type == OP_NIP) begin
      sp_upd = sp - PW'(1);
    end else if (req.req_type == OP_DROP2) begin
      sp_upd = sp - PW'(2);
    end else if (req.req_type == OP_CLEAR) begin
      sp_upd = '0;
    end
  end

  // Reads walk down from the top: sp-1 at the transfer, then sp-2 and sp-3.
  always_comb begin
    rd_addr = sp_a - AW'(1);
    if (state == S_READ) begin
      rd_addr = sp_a - AW'(cnt) - AW'(2);
    end
  end

  assign depth_ent = {TAG_INT, DATA_WIDTH'(sp)};
  assign bool_ent  = {TAG_BOOL, DATA_WIDTH'(pred_hit(op, e1[EW-1 -: TAG_W]))};

  // Write plan: e1 is the top entry, e2 below it, e3 below that.
  always_comb begin
    slot_en = 3'b000;
    for (int k = 0; k < 3; k++) begin
      slot_addr[k] = sp_a;
      slot_data[k] = e1;
    end
    top_ent = e1;
    priority if (op == OP_PUSH) begin
      slot_en[0] = 1'b1; slot_data[0] = push_ent; top_ent = push_ent;
    end else if (op == OP_DEPTH) begin
      slot_en[0] = 1'b1; slot_data[0] = depth_ent; top_ent = depth_ent;
    end else if (op == OP_DROP) begin
      top_ent = e2;
    end else if (op == OP_DROP2) begin
      top_ent = e3;
    end else if (op == OP_DUP) begin
      slot_en[0] = 1'b1;
    end else if (op == OP_DUP2) begin
      slot_en[1:0] = 2'b11;
      slot_data[0] = e2;
      slot_addr[1] = sp_a + AW'(1);
    end else if (op == OP_NIP) begin
      slot_en[0] = 1'b1; slot_addr[0] = sp_a - AW'(2);
    end else if (op == OP_OVER) begin
      slot_en[0] = 1'b1; slot_data[0] = e2; top_ent = e2;
    end else if (op == OP_ROT) begin
      slot_en = 3'b111;
      slot_addr[0] = sp_a - AW'(3); slot_data[0] = e2;
      slot_addr[1] = sp_a - AW'(2); slot_data[1] = e1;
      slot_addr[2] = sp_a - AW'(1); slot_data[2] = e3;
      top_ent = e3;
    end else if (op == OP_SWAP) begin
      slot_en[1:0] = 2'b11;
      slot_addr[0] = sp_a - AW'(2); slot_data[0] = e1;
      slot_addr[1] = sp_a - AW'(1); slot_data[1] = e2;
      top_ent = e2;
    end else if (op >= OP_IS_BOOL && op <= OP_IS_FUNC) begin
      slot_en[0] = 1'b1; slot_addr[0] = sp_a - AW'(1); slot_data[0] = bool_ent;
      top_ent = bool_ent;
    end else begin
      // Clear and unused codes write nothing.
      slot_en = 3'b000;
    end
    // A failed operation leaves the stack and its top as they were.
    if (st != ST_OK) begin
      slot_en = 3'b000;
      top_ent = e1;
    end
  end

  assign wr_en   = (state == S_WRITE) && (cnt != 2'd3) && slot_en[cnt];
  assign wr_addr = slot_addr[cnt];
  assign wr_data = slot_data[cnt];
  assign res_sp  = (st == ST_OK) ? sp_new : sp;

  dsou_ram #(
    .WIDTH (EW),
    .DEPTH (STACK_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= 2'd0;
      sp    <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op       <= req.req_type;
            st       <= st_in;
            sp_new   <= sp_upd;
            push_ent <= {req.push_tag, req.push_data[DATA_WIDTH-1:0]};
            cnt      <= 2'd0;
            state    <= S_READ;
          end
        end
        S_READ: begin
          unique case (cnt)
            2'd0:    e1 <= rd_data;
            2'd1:    e2 <= rd_data;
            default: e3 <= rd_data;
          endcase
          if (cnt == 2'd2) begin
            cnt   <= 2'd0;
            state <= S_WRITE;
          end else begin
            cnt <= cnt + 2'd1;
          end
        end
        S_WRITE: begin
          if (cnt == 2'd2) begin
            cnt                <= 2'd0;
            state              <= S_IDLE;
            done               <= 1'b1;
            sp                 <= res_sp;
            result.status      <= st;
            result.stack_depth <= DEPTH_OUT_W'(res_sp);
            result.top_valid   <= (res_sp != '0);
            result.top_tag     <= (res_sp != '0) ? top_ent[EW-1 -: TAG_W] : '0;
            result.top_data    <= (res_sp != '0) ?
                                  PORT_DATA_W'(top_ent[DATA_WIDTH-1:0]) : '0;
          end else begin
            cnt <= cnt + 2'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `DSOU_ASSERT_SAME(a_sp_range, clk, rst, 1'b1, sp <= PW'(STACK_DEPTH), "pointer beyond depth")
  `DSOU_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "transfer did not raise busy")
  `DSOU_ASSERT_SAME(a_err_hold, clk, rst, done && result.status != ST_OK, sp == $past(sp), "error moved pointer")
  `DSOU_ASSERT_SAME(a_wr_phase, clk, rst, wr_en, state == S_WRITE, "entry write outside write phase")

endmodule

`default_nettype wire

FILE: tb/tb_data_stack_operation_unit.sv
// ----------------------------------------------------------------------------
// Data stack operation unit testbench
// Drives stack words, value pushes and type predicates into the unit, keeps
// its own copy of the tagged stack to predict every result, and compares each
// result field by field under several pacing phases of the start side.
// ----------------------------------------------------------------------------
module tb_data_stack_operation_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import dsou_pkg::*;

  localparam int STACK_SLOTS = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  // Highest request code; everything above OP_IS_FUNC is unused.
  localparam logic [OP_W-1:0] OP_UNUSED_TOP = 5'd31;
  // Tag outside the defined set; every predicate answers false for it.
  localparam logic [TAG_W-1:0] TAG_UNDEF = 3'd7;

  typedef struct packed {
    logic [TAG_W-1:0]       tag;
    logic [PORT_DATA_W-1:0] data;
  } slot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  res_t result;

  req_t pending_ops[$];
  res_t predicted_results[$];

  slot_t stack_mem [STACK_SLOTS];
  int stack_ptr = 0;

  int idle_pct = 0;
  int quiet_cycles = 0;
  int fail_count = 0;
  int ops_accepted = 0;
  int results_checked = 0;
  int underflow_hits = 0;
  int overflow_hits = 0;
  int deepest = 0;

  data_stack_operation_unit #(
    .STACK_DEPTH(STACK_SLOTS),
    .DATA_WIDTH (PORT_DATA_W)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  always #2 clk = ~clk;

  // Applies one operation to the model stack and returns the result it yields.
  function automatic res_t apply_stack_op(input req_t r);
    res_t  o;
    slot_t a;
    slot_t b;
    slot_t c;
    int    need;
    int    grow;
    logic  known;
    logic  hit;
    o = '0;
    need = 0;
    grow = 0;
    hit = 1'b0;
    known = (r.req_type <= OP_IS_FUNC);
    case (r.req_type)
      OP_PUSH, OP_DEPTH: grow = 1;
      OP_DROP: begin
        need = 1;
        grow = -1;
      end
      OP_DROP2: begin
        need = 2;
        grow = -2;
      end
      OP_DUP: begin
        need = 1;
        grow = 1;
      end
      OP_DUP2: begin
        need = 2;
        grow = 2;
      end
      OP_NIP: begin
        need = 2;
        grow = -1;
      end
      OP_OVER: begin
        need = 2;
        grow = 1;
      end
      OP_ROT: need = 3;
      OP_SWAP: need = 2;
      OP_IS_BOOL, OP_IS_NUM, OP_IS_INT, OP_IS_REAL, OP_IS_RATIO, OP_IS_STRING,
      OP_IS_LIST, OP_IS_FUNC: need = 1;
      default: ;
    endcase
    if (known && stack_ptr < need) begin
      o.status = ST_UNDER;
      underflow_hits++;
    end else if (known && grow > 0 && stack_ptr + grow > STACK_SLOTS) begin
      o.status = ST_OVER;
      overflow_hits++;
    end else if (known) begin
      o.status = ST_OK;
      case (r.req_type)
        OP_PUSH: begin
          stack_mem[stack_ptr].tag = r.push_tag;
          stack_mem[stack_ptr].data = r.push_data;
        end
        OP_DEPTH: begin
          stack_mem[stack_ptr].tag = TAG_INT;
          stack_mem[stack_ptr].data = PORT_DATA_W'(stack_ptr);
        end
        OP_DUP: stack_mem[stack_ptr] = stack_mem[stack_ptr-1];
        OP_DUP2: begin
          stack_mem[stack_ptr] = stack_mem[stack_ptr-2];
          stack_mem[stack_ptr+1] = stack_mem[stack_ptr-1];
        end
        OP_NIP: stack_mem[stack_ptr-2] = stack_mem[stack_ptr-1];
        OP_OVER: stack_mem[stack_ptr] = stack_mem[stack_ptr-2];
        OP_ROT: begin
          a = stack_mem[stack_ptr-3];
          b = stack_mem[stack_ptr-2];
          c = stack_mem[stack_ptr-1];
          stack_mem[stack_ptr-3] = b;
          stack_mem[stack_ptr-2] = c;
          stack_mem[stack_ptr-1] = a;
        end
        OP_SWAP: begin
          a = stack_mem[stack_ptr-2];
          stack_mem[stack_ptr-2] = stack_mem[stack_ptr-1];
          stack_mem[stack_ptr-1] = a;
        end
        OP_IS_BOOL, OP_IS_NUM, OP_IS_INT, OP_IS_REAL, OP_IS_RATIO, OP_IS_STRING,
        OP_IS_LIST, OP_IS_FUNC: begin
          a = stack_mem[stack_ptr-1];
          case (r.req_type)
            OP_IS_BOOL:   hit = (a.tag == TAG_BOOL);
            OP_IS_NUM:    hit = (a.tag == TAG_INT) || (a.tag == TAG_REAL) ||
                                (a.tag == TAG_RATIO);
            OP_IS_INT:    hit = (a.tag == TAG_INT);
            OP_IS_REAL:   hit = (a.tag == TAG_REAL);
            OP_IS_RATIO:  hit = (a.tag == TAG_RATIO);
            OP_IS_STRING: hit = (a.tag == TAG_STRING);
            OP_IS_LIST:   hit = (a.tag == TAG_LIST);
            default:      hit = (a.tag == TAG_FUNCTION);
          endcase
          stack_mem[stack_ptr-1].tag = TAG_BOOL;
          stack_mem[stack_ptr-1].data = PORT_DATA_W'(hit);
        end
        default: ;
      endcase
      if (r.req_type == OP_CLEAR) begin
        stack_ptr = 0;
      end else begin
        stack_ptr = stack_ptr + grow;
      end
    end else begin
      o.status = ST_OK;
    end
    if (stack_ptr > deepest) deepest = stack_ptr;
    o.stack_depth = DEPTH_OUT_W'(stack_ptr);
    if (stack_ptr > 0) begin
      o.top_valid = 1'b1;
      o.top_tag = stack_mem[stack_ptr-1].tag;
      o.top_data = stack_mem[stack_ptr-1].data;
    end
    return o;
  endfunction

  task automatic add_op(input logic [OP_W-1:0] code, input logic [TAG_W-1:0] tag,
                        input logic [PORT_DATA_W-1:0] data);
    req_t it;
    it.req_type = code;
    it.push_tag = tag;
    it.push_data = data;
    pending_ops.push_back(it);
  endtask

  // Random operations in segments that mostly grow, mostly shrink or mix, so
  // that the stack swings between empty and full.
  task automatic fill_random(input int count);
    req_t it;
    int   mode;
    int   seg_left;
    int   r;
    int   n;
    mode = 0;
    seg_left = 0;
    for (n = 0; n < count; n++) begin
      if (seg_left == 0) begin
        mode = $urandom_range(0, 2);
        seg_left = (mode == 0) ? 70 : $urandom_range(10, 40);
      end
      seg_left--;
      it.push_tag = TAG_W'($urandom_range(0, 6));
      if ($urandom_range(0, 19) == 0) it.push_tag = TAG_UNDEF;
      r = $urandom_range(0, 99);
      if (r < 10) begin
        it.push_data = '0;
      end else if (r < 20) begin
        it.push_data = '1;
      end else begin
        it.push_data = {$urandom, $urandom};
      end
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 8) begin
        it.req_type = OP_W'($urandom_range(0, 31));
        it.push_tag = TAG_W'($urandom_range(0, 7));
      end else if (mode == 0) begin
        if (r < 55) it.req_type = OP_PUSH;
        else if (r < 65) it.req_type = OP_DUP;
        else if (r < 75) it.req_type = OP_DUP2;
        else if (r < 82) it.req_type = OP_OVER;
        else if (r < 88) it.req_type = OP_DEPTH;
        else it.req_type = OP_W'($urandom_range(OP_DROP, OP_IS_FUNC));
      end else if (mode == 1) begin
        if (r < 30) it.req_type = OP_DROP;
        else if (r < 50) it.req_type = OP_DROP2;
        else if (r < 65) it.req_type = OP_NIP;
        else if (r < 68) it.req_type = OP_CLEAR;
        else if (r < 78) it.req_type = OP_PUSH;
        else it.req_type = OP_W'($urandom_range(OP_DROP, OP_IS_FUNC));
      end else begin
        it.req_type = OP_W'($urandom_range(OP_PUSH, OP_IS_FUNC));
      end
      pending_ops.push_back(it);
    end
  endtask

  task automatic check_field(input string name, input logic [PORT_DATA_W-1:0] exp_val,
                             input logic [PORT_DATA_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // Start side: a request is held until it transfers.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      req <= '0;
    end else begin
      if (start && !busy) begin
        predicted_results.push_back(apply_stack_op(req));
        ops_accepted++;
      end
      if (!start || !busy) begin
        if (pending_ops.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          start <= 1'b1;
          req <= pending_ops.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result side: every done pulse carries one result.
  always @(posedge clk) begin
    res_t exp_res;
    if (!rst && done) begin
      if (predicted_results.size() == 0) begin
        $error("result with no operation waiting for it");
        fail_count++;
      end else begin
        exp_res = predicted_results.pop_front();
        results_checked++;
        check_field("status", PORT_DATA_W'(exp_res.status), PORT_DATA_W'(result.status));
        check_field("stack_depth", PORT_DATA_W'(exp_res.stack_depth),
                    PORT_DATA_W'(result.stack_depth));
        check_field("top_valid", PORT_DATA_W'(exp_res.top_valid),
                    PORT_DATA_W'(result.top_valid));
        check_field("top_tag", PORT_DATA_W'(exp_res.top_tag), PORT_DATA_W'(result.top_tag));
        check_field("top_data", exp_res.top_data, result.top_data);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Underflow when empty, extreme push payloads, stack words, predicates.
    add_op(OP_DROP, TAG_BOOL, '0);
    add_op(OP_ROT, TAG_BOOL, '0);
    add_op(OP_IS_NUM, TAG_BOOL, '0);
    add_op(OP_PUSH, TAG_INT, '0);
    add_op(OP_PUSH, TAG_UNDEF, '1);
    add_op(OP_PUSH, TAG_REAL, 64'h8000_0000_0000_0001);
    add_op(OP_OVER, TAG_BOOL, '0);
    add_op(OP_ROT, TAG_BOOL, '0);
    add_op(OP_SWAP, TAG_BOOL, '0);
    add_op(OP_NIP, TAG_BOOL, '0);
    add_op(OP_DUP, TAG_BOOL, '0);
    add_op(OP_DUP2, TAG_BOOL, '0);
    add_op(OP_DEPTH, TAG_BOOL, '0);
    add_op(OP_IS_INT, TAG_BOOL, '0);
    add_op(OP_PUSH, TAG_RATIO, 64'h0123_4567_89ab_cdef);
    add_op(OP_IS_NUM, TAG_BOOL, '0);
    add_op(OP_PUSH, TAG_UNDEF, 64'h5555_5555_5555_5555);
    add_op(OP_IS_BOOL, TAG_BOOL, '0);
    add_op(OP_PUSH, TAG_STRING, 64'haaaa_aaaa_aaaa_aaaa);
    add_op(OP_IS_STRING, TAG_BOOL, '0);
    add_op(OP_DROP2, TAG_BOOL, '0);
    add_op(OP_UNUSED_TOP, TAG_UNDEF, '1);
    add_op(OP_CLEAR, TAG_BOOL, '0);
    add_op(OP_DROP, TAG_BOOL, '0);
    add_op(OP_PUSH, TAG_FUNCTION, 64'hffff_0000_ffff_0000);
    add_op(OP_IS_FUNC, TAG_BOOL, '0);

    // Pacing phases: back to back, sparse starts, back to back, rare gaps.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        1:       idle_pct = 67;
        3:       idle_pct = 6;
        default: idle_pct = 0;
      endcase
      fill_random(130);
      while (pending_ops.size() != 0 || start || predicted_results.size() != 0)
        @(posedge clk);
    end
    repeat (12) @(posedge clk);

    if (predicted_results.size() != 0) begin
      $error("%0d results never arrived", predicted_results.size());
      fail_count++;
    end
    $display("Ran %0d stack operations over four pacing phases, %0d results checked.",
             ops_accepted, results_checked);
    $display("Underflow rejections %0d, overflow rejections %0d, deepest stack %0d.",
             underflow_hits, overflow_hits, deepest);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/dsou_pkg.sv
sv/dsou_ram.sv
sv/data_stack_operation_unit.sv
tb/tb_data_stack_operation_unit.sv
